FILE: rtl/scvs_pkg.sv
// Shared types, register offsets and widths of the vetoed scaler.
package scvs_pkg;

  localparam int CHANNELS_DEF     = 16;
  localparam int COUNTER_BITS_DEF = 32;

  localparam int MODE_W     = 8;
  localparam int SERIAL_W   = 16;
  localparam int IDENT_W    = 16;
  localparam int GEO_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int ACTION_W = 2;
  localparam int OFFSET_W = 8;
  localparam int WDATA_W  = 16;
  localparam int PULSE_W  = 16;
  localparam int RDATA_W  = 32;
  localparam int LEVEL_W  = 3;
  localparam int VECTOR_W = 8;
  localparam int SOURCE_W = 8;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [ACTION_W-1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_TICK  = 2'd2
  } action_e;

  localparam logic [CFG_IDX_W-1:0] CFG_SECTION_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION_SERIAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOARD_IDENT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GEO_SLOT       = 2'd3;

  localparam logic [OFFSET_W-1:0] OFF_VECTOR       = 8'h04;
  localparam logic [OFFSET_W-1:0] OFF_LEVEL        = 8'h06;
  localparam logic [OFFSET_W-1:0] OFF_INT_EN       = 8'h08;
  localparam logic [OFFSET_W-1:0] OFF_INT_DIS      = 8'h0A;
  localparam logic [OFFSET_W-1:0] OFF_INT_ACK      = 8'h0C;
  localparam logic [OFFSET_W-1:0] OFF_SOURCE       = 8'h0E;
  localparam logic [OFFSET_W-1:0] OFF_COUNTER_BASE = 8'h10;
  localparam logic [OFFSET_W-1:0] OFF_CLEAR        = 8'h50;
  localparam logic [OFFSET_W-1:0] OFF_VETO_SET     = 8'h52;
  localparam logic [OFFSET_W-1:0] OFF_VETO_CLR     = 8'h54;
  localparam logic [OFFSET_W-1:0] OFF_SW_INC       = 8'h56;
  localparam logic [OFFSET_W-1:0] OFF_MODE         = 8'h58;
  localparam logic [OFFSET_W-1:0] OFF_GEO          = 8'hFA;
  localparam logic [OFFSET_W-1:0] OFF_IDENT        = 8'hFC;
  localparam logic [OFFSET_W-1:0] OFF_VERSION      = 8'hFE;

  localparam int MAX_MODE_SECTIONS = 8;

  typedef struct packed {
    logic clr;
    logic cnt_en;
  } lane_cmd_t;

  // Mode bit order: sections 0..3 on bits 3..0, sections 4..7 on bits 7..4.
  function automatic logic [2:0] mode_bit(input int unsigned s);
    return (s < 4) ? 3'(3 - s) : 3'(11 - s);
  endfunction

endpackage

FILE: rtl/scvs_lane.sv
// One section lane: a pair of counters that may be joined into one double-width counter.
module scvs_lane import scvs_pkg::*; #(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF,
  parameter bit INT_OK       = 1'b1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lane_cmd_t               cmd_i,
  input  logic                    hit_lo_i,
  input  logic                    hit_hi_i,
  input  logic                    joined_i,
  output logic [COUNTER_BITS-1:0] cnt_lo_o,
  output logic [COUNTER_BITS-1:0] cnt_hi_o,
  output logic                    rise_o
);

  logic [COUNTER_BITS-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [COUNTER_BITS-1:0] lo_inc, hi_inc;
  logic                    lo_step, hi_step, rise_lo, rise_hi;

  always_comb begin
    lo_inc  = lo_q + COUNTER_BITS'(1);
    hi_inc  = hi_q + COUNTER_BITS'(1);
    lo_step = cmd_i.cnt_en & hit_lo_i;
    hi_step = joined_i ? (lo_step & (&lo_q)) : (cmd_i.cnt_en & hit_hi_i);
    rise_lo = lo_step & ~lo_q[COUNTER_BITS-1] & lo_inc[COUNTER_BITS-1];
    rise_hi = hi_step & ~hi_q[COUNTER_BITS-1] & hi_inc[COUNTER_BITS-1];
    rise_o  = INT_OK & (joined_i ? rise_hi : (rise_hi | rise_lo));
    lo_d = lo_q;
    hi_d = hi_q;
    if (cmd_i.clr) begin
      lo_d = '0;
      hi_d = '0;
    end else begin
      if (lo_step) begin
        lo_d = lo_inc;
      end
      if (hi_step) begin
        hi_d = hi_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= '0;
      hi_q <= '0;
    end else begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  assign cnt_lo_o = lo_q;
  assign cnt_hi_o = hi_q;

  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr |=> (lo_q == '0) && (hi_q == '0))
    else $error("counters not zero after clear");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cmd_i.cnt_en && !cmd_i.clr) |=> $stable(lo_q) && $stable(hi_q))
    else $error("counter moved without a count or clear");

  a_joined_carry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (joined_i && cmd_i.cnt_en && !cmd_i.clr && hit_lo_i && (&lo_q))
      |=> (hi_q == COUNTER_BITS'($past(hi_q) + COUNTER_BITS'(1))) && (lo_q == '0))
    else $error("joined section lost a carry");

endmodule

FILE: rtl/scvs_regs.sv
// Register file, bus decode and merge of lane results into the output register.
module scvs_regs import scvs_pkg::*; #(
  parameter int CHANNELS     = CHANNELS_DEF,
  parameter int COUNTER_BITS = COUNTER_BITS_DEF,
  localparam int NSEC        = (CHANNELS + 1) / 2
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [IN_DATA_W-1:0]    s_axis_tdata,
  input  logic [ACTION_W-1:0]     s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [COUNTER_BITS-1:0] cnt_i [CHANNELS],
  input  logic [NSEC-1:0]         rise_i,
  output logic [NSEC-1:0]         joined_o,
  output logic [CHANNELS-1:0]     hits_o,
  output lane_cmd_t               cmd_o
);

  localparam int SECTIONS = CHANNELS / 2;
  localparam int IDX_W    = $clog2(CHANNELS);
  localparam int HIT_W    = (CHANNELS > PULSE_W) ? CHANNELS : PULSE_W;
  localparam logic [6:0] CH_LIMIT = 7'(CHANNELS);

  action_e               act;
  logic [OFFSET_W-1:0]   offset;
  logic [WDATA_W-1:0]    wdata;
  logic [PULSE_W-1:0]    pulses;
  logic [HIT_W-1:0]      pulses_ext;
  logic [OFFSET_W-1:0]   rel;
  logic [5:0]            ch_full;
  logic                  cnt_sel_ok;
  logic [IDX_W-1:0]      cnt_idx;
  logic                  accept;
  logic [NSEC-1:0]       src_mask;
  logic [RDATA_W-1:0]    rd;
  logic                  rej;
  logic                  pending_base;

  logic                  veto_active_q, veto_active_d;
  logic                  veto_latched_q, veto_latched_d;
  logic [LEVEL_W-1:0]    level_q, level_d;
  logic [VECTOR_W-1:0]   vector_q, vector_d;
  logic [SOURCE_W-1:0]   source_q, source_d;
  logic                  int_en_q, int_en_d;
  logic                  pending_q, pending_d;
  logic [MODE_W-1:0]     mode_q, mode_d;
  logic [SERIAL_W-1:0]   serial_q, serial_d;
  logic [IDENT_W-1:0]    ident_q, ident_d;
  logic [GEO_W-1:0]      geo_q, geo_d;
  logic                  m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;

  assign act        = action_e'(s_axis_tuser);
  assign offset     = s_axis_tdata[7:0];
  assign wdata      = s_axis_tdata[23:8];
  assign pulses     = s_axis_tdata[39:24];
  assign pulses_ext = HIT_W'(pulses);
  assign rel        = offset - OFF_COUNTER_BASE;
  assign ch_full    = rel[7:2];
  assign cnt_idx    = ch_full[IDX_W-1:0];
  assign cnt_sel_ok = (offset >= OFF_COUNTER_BASE) && ({1'b0, ch_full} < CH_LIMIT);

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    for (int s = 0; s < NSEC; s++) begin
      src_mask[s] = (s < SOURCE_W) ? source_q[s[2:0]] : 1'b0;
      joined_o[s] = ((s < SECTIONS) && (s < MAX_MODE_SECTIONS))
                    ? mode_q[mode_bit(s)] : 1'b0;
    end
  end

  always_comb begin
    veto_active_d  = veto_active_q;
    veto_latched_d = veto_latched_q;
    level_d        = level_q;
    vector_d       = vector_q;
    source_d       = source_q;
    int_en_d       = int_en_q;
    pending_base   = pending_q;
    rd             = '0;
    rej            = 1'b0;
    cmd_o          = '0;
    hits_o         = pulses_ext[CHANNELS-1:0];
    if (accept) begin
      case (act)
        ACT_READ: begin
          case (offset)
            OFF_VECTOR:  rd = RDATA_W'(vector_q);
            OFF_LEVEL:   rd = RDATA_W'({veto_latched_q, 4'b0000, level_q});
            OFF_SOURCE:  rd = RDATA_W'(source_q);
            OFF_MODE:    rd = RDATA_W'(mode_q);
            OFF_GEO:     rd = RDATA_W'(geo_q);
            OFF_IDENT:   rd = RDATA_W'(ident_q);
            OFF_VERSION: rd = RDATA_W'(serial_q);
            default: begin
              if (cnt_sel_ok) begin
                veto_latched_d = !veto_active_q;
                rd             = RDATA_W'(cnt_i[cnt_idx]);
              end
            end
          endcase
        end
        ACT_WRITE: begin
          case (offset)
            OFF_VECTOR: begin
              vector_d = wdata[VECTOR_W-1:0];
              rej      = |wdata[WDATA_W-1:VECTOR_W];
            end
            OFF_LEVEL: begin
              level_d = wdata[LEVEL_W-1:0];
              rej     = |wdata[WDATA_W-1:LEVEL_W];
            end
            OFF_SOURCE: begin
              source_d = wdata[SOURCE_W-1:0];
              rej      = |wdata[WDATA_W-1:SOURCE_W];
            end
            OFF_INT_EN:   int_en_d = 1'b1;
            OFF_INT_DIS:  int_en_d = 1'b0;
            OFF_INT_ACK:  pending_base = 1'b0;
            OFF_CLEAR: begin
              cmd_o.clr    = 1'b1;
              pending_base = 1'b0;
              int_en_d     = 1'b0;
            end
            OFF_VETO_SET: veto_active_d = 1'b1;
            OFF_VETO_CLR: veto_active_d = 1'b0;
            OFF_SW_INC: begin
              cmd_o.cnt_en = !veto_active_q;
              hits_o       = '1;
            end
            default: ;
          endcase
        end
        ACT_TICK: cmd_o.cnt_en = !veto_active_q;
        default: ;
      endcase
    end
  end

  assign pending_d = pending_base | (|(rise_i & src_mask));

  always_comb begin
    mode_d   = mode_q;
    serial_d = serial_q;
    ident_d  = ident_q;
    geo_d    = geo_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SECTION_MODE:   mode_d   = cfg_data_i[MODE_W-1:0];
        CFG_VERSION_SERIAL: serial_d = cfg_data_i[SERIAL_W-1:0];
        CFG_BOARD_IDENT:    ident_d  = cfg_data_i[IDENT_W-1:0];
        CFG_GEO_SLOT:       geo_d    = cfg_data_i[GEO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (accept) begin
      m_valid_d = 1'b1;
      m_data_d  = {3'b000, vector_d, level_d, pending_d & int_en_d, rej, rd};
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      veto_active_q  <= 1'b1;
      veto_latched_q <= 1'b0;
      level_q        <= '0;
      vector_q       <= '0;
      source_q       <= '0;
      int_en_q       <= 1'b0;
      pending_q      <= 1'b0;
      mode_q         <= '0;
      serial_q       <= '0;
      ident_q        <= '0;
      geo_q          <= '0;
      m_valid_q      <= 1'b0;
    end else begin
      veto_active_q  <= veto_active_d;
      veto_latched_q <= veto_latched_d;
      level_q        <= level_d;
      vector_q       <= vector_d;
      source_q       <= source_d;
      int_en_q       <= int_en_d;
      pending_q      <= pending_d;
      mode_q         <= mode_d;
      serial_q       <= serial_d;
      ident_q        <= ident_d;
      geo_q          <= geo_d;
      m_valid_q      <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_clear_drops_irq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (act == ACT_WRITE) && (offset == OFF_CLEAR)) |=> !pending_q && !int_en_q)
    else $error("clear left the interrupt armed");

  a_veto_blocks_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.cnt_en |-> !veto_active_q)
    else $error("count issued under veto");

  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while the output register is stalled");

endmodule

FILE: rtl/sixteen_channel_vetoed_scaler.sv
// Top level of the sixteen-channel vetoed scaler: section lanes and register merge.
//
// Input channel s_axis: one transaction per bus read, bus write or count tick; tuser
// carries the action, tdata the offset, write data and per-channel pulses.
// Output channel m_axis: exactly one transaction per input transaction, in order,
// carrying the read data, the rejected-write flag and the interrupt state after the
// transaction took effect.
// A result appears on m_axis in the cycle after its input is taken.
// Throughput is one transaction per cycle unless m_axis stalls; every lane updates
// its counter pair in the same cycle, so a tick on every clock is counted without loss.
// The configuration port writes section mode, version/serial, board ident and slot;
// the user writes only while the block is idle (unchecked); it acts on the next transaction.
// Reset zeroes all counters, sets the veto (counting inhibited) and clears all
// interrupt state and configuration.
// When the receiver stalls, the result waits in the output register and s_axis_tready
// stays low until it is taken; nothing is dropped.
module sixteen_channel_vetoed_scaler import scvs_pkg::*; #(
  parameter int CHANNELS     = CHANNELS_DEF,
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // offset [7:0], write_data [23:8], pulses [39:24]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // action [1:0]
  input  logic [ACTION_W-1:0]   s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // read_data [31:0], write_rejected [32], irq_request [33], irq_level [36:34],
  // irq_vector [44:37], zero [47:45]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int NSEC     = (CHANNELS + 1) / 2;
  localparam int SECTIONS = CHANNELS / 2;

  logic [COUNTER_BITS-1:0] cnt [CHANNELS];
  logic [NSEC-1:0]         rise;
  logic [NSEC-1:0]         joined;
  logic [CHANNELS-1:0]     hits;
  lane_cmd_t               cmd;

  scvs_regs #(
    .CHANNELS     (CHANNELS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .cnt_i         (cnt),
    .rise_i        (rise),
    .joined_o      (joined),
    .hits_o        (hits),
    .cmd_o         (cmd)
  );

  for (genvar s = 0; s < NSEC; s++) begin : g_lane
    localparam bit INT_OK = (s < SECTIONS) && (s < MAX_MODE_SECTIONS);
    if (2 * s + 1 < CHANNELS) begin : g_pair
      scvs_lane #(
        .COUNTER_BITS (COUNTER_BITS),
        .INT_OK       (INT_OK)
      ) u_lane (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .cmd_i    (cmd),
        .hit_lo_i (hits[2*s]),
        .hit_hi_i (hits[2*s+1]),
        .joined_i (joined[s]),
        .cnt_lo_o (cnt[2*s]),
        .cnt_hi_o (cnt[2*s+1]),
        .rise_o   (rise[s])
      );
    end else begin : g_single
      scvs_lane #(
        .COUNTER_BITS (COUNTER_BITS),
        .INT_OK       (1'b0)
      ) u_lane (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .cmd_i    (cmd),
        .hit_lo_i (hits[2*s]),
        .hit_hi_i (1'b0),
        .joined_i (joined[s]),
        .cnt_lo_o (cnt[2*s]),
        .cnt_hi_o (),
        .rise_o   (rise[s])
      );
    end
  end

endmodule
